@@ src/htl_pkg.sv @@
// ============================================================================
// htl_pkg - shared types and constants of the humidity/temperature linearizer
// Beat formats, stage boundary records and the fixed-point coefficient set.
// Polynomial coefficients are held in Q30 and already scaled by 100, so the
// pipeline forms 100 * RH directly in Q30.
// ============================================================================
`default_nettype none

package htl_pkg;

    // Fixed-point format of the humidity path
    localparam int FRAC_BITS = 30;
    localparam int SUM_W     = 56;

    // Temperature conversion, hundredths of a degree
    localparam logic signed [17:0] TEMP_OFFSET_CENTI = -18'sd4010;
    localparam logic signed [17:0] TEMP_MAX_CENTI    = 18'sd12373;
    localparam logic signed [14:0] TEMP_REF_CENTI    = 15'sd2500;

    // Humidity clamp limits, hundredths of a percent
    localparam logic [13:0] HUMID_MIN_CENTI = 14'd10;
    localparam logic [13:0] HUMID_MAX_CENTI = 14'd10000;

    // Rounding and low clamp thresholds in Q30, high clamp limit in whole units
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] LOW_LIMIT =
        SUM_W'(HUMID_MIN_CENTI) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HIGH_LIMIT =
        SUM_W'(HUMID_MAX_CENTI);

    // 100 * round(K * 2^30): offset, linear and quadratic terms
    localparam logic signed [38:0] C1X    = -39'sd219773476500;
    localparam logic signed [36:0] C2X_HI = 37'sd3940632500;
    localparam logic signed [36:0] C2X_LO = 37'sd63050119900;
    localparam logic signed [26:0] C3X_HI = -27'sd171300;
    localparam logic signed [26:0] C3X_LO = -27'sd43857000;

    // round(K * 2^30): temperature correction terms (not scaled)
    localparam logic [23:0] T1_Q  = 24'd10737418;
    localparam logic [20:0] T2_HI = 21'd85899;
    localparam logic [20:0] T2_LO = 21'd1374390;

    // Sample beat
    typedef struct packed {
        logic [13:0] temp_count;
        logic [11:0] humid_count;
    } htl_in_t;

    // Result beat
    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic        [13:0] humid_centi;
    } htl_out_t;

    // Front stage to polynomial stages
    typedef struct packed {
        logic signed [14:0] tc;
        logic signed [14:0] dt;
        logic        [11:0] h;
        logic               low_res;
    } htl_temp_t;

    // Polynomial stages to clamp stage
    typedef struct packed {
        logic signed [14:0]      tc;
        logic signed [SUM_W-1:0] v;
    } htl_sum_t;

endpackage

`default_nettype wire

@@ src/htl_temp.sv @@
// ============================================================================
// htl_temp - temperature scaling stage
// Scales the raw count to hundredths of a degree, saturates the low
// resolution range and forms the offset from 25 C for compensation.
// ============================================================================
`default_nettype none

module htl_temp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              low_res,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire htl_pkg::htl_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output htl_pkg::htl_temp_t     out_data
);
    import htl_pkg::*;

    logic               valid_reg;
    htl_temp_t          data_reg;
    htl_temp_t          data_next;
    logic signed [17:0] scaled;
    logic signed [17:0] tc_wide;
    logic signed [17:0] tc_sat;

    // Scale, offset and saturate the temperature
    always_comb
    begin
        if (low_res)
        begin
            scaled = $signed({2'b00, in_data.temp_count, 2'b00});
        end
        else
        begin
            scaled = $signed({4'b0000, in_data.temp_count});
        end
        tc_wide = scaled + TEMP_OFFSET_CENTI;
        if (tc_wide > TEMP_MAX_CENTI)
        begin
            tc_sat = TEMP_MAX_CENTI;
        end
        else
        begin
            tc_sat = tc_wide;
        end
        data_next.tc      = tc_sat[14:0];
        data_next.dt      = tc_sat[14:0] - TEMP_REF_CENTI;
        data_next.h       = in_data.humid_count;
        data_next.low_res = low_res;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ src/htl_poly.sv @@
// ============================================================================
// htl_poly - humidity polynomial stages
// Three register stages: products of the count, products with the square
// and the temperature offset, then the rounded Q30 sum of 100 * RH.
// ============================================================================
`default_nettype none

module htl_poly (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire htl_pkg::htl_temp_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output htl_pkg::htl_sum_t        out_data
);
    import htl_pkg::*;

    typedef struct packed {
        logic signed [14:0] tc;
        logic signed [14:0] dt;
        logic               low_res;
        logic signed [49:0] p_c2h;
        logic        [23:0] h2;
        logic        [33:0] w;
    } prod_t;

    typedef struct packed {
        logic signed [14:0] tc;
        logic signed [50:0] lin;
        logic signed [51:0] q_c3;
        logic signed [49:0] q_td;
    } term_t;

    logic               s2_valid_reg;
    logic               s3_valid_reg;
    logic               s4_valid_reg;
    prod_t              s2_reg;
    prod_t              s2_next;
    term_t              s3_reg;
    term_t              s3_next;
    htl_sum_t           s4_reg;
    htl_sum_t           s4_next;
    logic               s2_ready;
    logic               s3_ready;
    logic               s4_ready;
    logic signed [36:0] c2_sel;
    logic        [20:0] t2_sel;
    logic signed [26:0] c3_sel;

    // Stage 2: linear products and the square of the count
    always_comb
    begin
        c2_sel         = in_data.low_res ? C2X_LO : C2X_HI;
        t2_sel         = in_data.low_res ? T2_LO : T2_HI;
        s2_next.tc     = in_data.tc;
        s2_next.dt     = in_data.dt;
        s2_next.low_res = in_data.low_res;
        s2_next.p_c2h  = 50'(c2_sel) * 50'($signed({1'b0, in_data.h}));
        s2_next.h2     = 24'(in_data.h) * 24'(in_data.h);
        s2_next.w      = 34'(T1_Q) + 34'(t2_sel) * 34'(in_data.h);
    end

    // Stage 3: quadratic term, correction term and offset sum
    always_comb
    begin
        c3_sel       = s2_reg.low_res ? C3X_LO : C3X_HI;
        s3_next.tc   = s2_reg.tc;
        s3_next.lin  = 51'(C1X) + 51'(s2_reg.p_c2h);
        s3_next.q_c3 = 52'(c3_sel) * 52'($signed({1'b0, s2_reg.h2}));
        s3_next.q_td = 50'($signed({1'b0, s2_reg.w})) * 50'(s2_reg.dt);
    end

    // Stage 4: total with the rounding half added
    always_comb
    begin
        s4_next.tc = s3_reg.tc;
        s4_next.v  = SUM_W'(s3_reg.lin) + SUM_W'(s3_reg.q_c3)
                   + SUM_W'(s3_reg.q_td) + ROUND_HALF;
    end

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Load the payloads, hold on stall
    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

endmodule

`default_nettype wire

@@ src/htl_clamp.sv @@
// ============================================================================
// htl_clamp - humidity clamp and result register
// Drops the fraction of the rounded sum, clamps it to 0.1..100 percent and
// holds the result beat until it is taken.
// ============================================================================
`default_nettype none

module htl_clamp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire htl_pkg::htl_sum_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output htl_pkg::htl_out_t       out_data
);
    import htl_pkg::*;

    logic                    valid_reg;
    htl_out_t                data_reg;
    htl_out_t                data_next;
    logic signed [SUM_W-1:0] whole;

    // Drop the fraction and clamp
    always_comb
    begin
        whole                = in_data.v >>> FRAC_BITS;
        data_next.temp_centi = in_data.tc;
        priority if (in_data.v < LOW_LIMIT)
        begin
            data_next.humid_centi = HUMID_MIN_CENTI;
        end
        else if (whole > HIGH_LIMIT)
        begin
            data_next.humid_centi = HUMID_MAX_CENTI;
        end
        else
        begin
            data_next.humid_centi = whole[13:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ src/humidity_temperature_linearizer.sv @@
// ============================================================================
// humidity_temperature_linearizer - raw sensor counts to calibrated values
// Converts a raw temperature/humidity count pair into temperature in 0.01 C
// and temperature-compensated relative humidity in 0.01 %RH.
//
//   channel   signals                        beat
//   sample    sample_valid / sample_ready    temp_count, humid_count
//   result    result_valid / result_ready    temp_centi, humid_centi
//   cfg       cfg_valid / cfg_ready          low_resolution (cfg_data)
//
// One sample beat per cycle while result is not stalled; five register
// stages (scale, products, square products, sum, clamp) lie between
// sample and result. cfg_ready is always high; the resolution bit is
// sampled at the scale stage. Reset clears all stage valid bits and
// selects high resolution. A stall on result holds every full stage in
// place; empty stages keep filling.
// ============================================================================
`default_nettype none

module humidity_temperature_linearizer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire htl_pkg::htl_in_t   sample,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output htl_pkg::htl_out_t       result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);
    import htl_pkg::*;

    logic      low_res_reg;
    logic      temp_valid;
    logic      temp_ready;
    htl_temp_t temp_data;
    logic      sum_valid;
    logic      sum_ready;
    htl_sum_t  sum_data;

    assign cfg_ready = 1'b1;

    // Hold the resolution select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_res_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            low_res_reg <= cfg_data;
        end
    end

    htl_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .low_res   (low_res_reg),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_data   (sample),
        .out_valid (temp_valid),
        .out_ready (temp_ready),
        .out_data  (temp_data)
    );

    htl_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (temp_valid),
        .in_ready  (temp_ready),
        .in_data   (temp_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    htl_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

endmodule

`default_nettype wire

@@ src/htl_checker.sv @@
// ============================================================================
// htl_checker - port-level checks of the linearizer
// Watches the sample and result channels for held beats and in-range values.
// ============================================================================
`default_nettype none

module htl_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    input  wire logic               sample_ready,
    input  wire htl_pkg::htl_in_t   sample,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire htl_pkg::htl_out_t  result,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready
);
    import htl_pkg::*;

    // Stalled sample beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("sample beat changed while stalled");

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // Humidity stays within the clamp limits
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.humid_centi >= HUMID_MIN_CENTI
                      && result.humid_centi <= HUMID_MAX_CENTI)
    else $error("humidity outside clamp limits");

    // Temperature stays within the converted range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.temp_centi >= -15'sd4010
                      && result.temp_centi <= 15'sd12373)
    else $error("temperature outside converted range");

    // Configuration port never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind humidity_temperature_linearizer htl_checker u_htl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

@@ tb/tb.sv @@
// ============================================================================
// tb - self-checking bench for the humidity/temperature linearizer
// Drives raw count pairs through the sample channel at both resolutions,
// predicts each calibrated result in 64-bit fixed point and checks every
// result beat, in order, against the prediction. Sender and receiver idle
// at random in three pressure modes.
// ============================================================================
`default_nettype none

module tb;

    import htl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PHASE   = 180;

    // Expected calibrated results, oldest first, plus the mismatch count
    class linearizer_scoreboard;
        htl_out_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // round(num * 2^FRAC_BITS / den), halves away from zero
        function longint fixed_coef(longint num, longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : longint'(num);
            q = ((mag << FRAC_BITS) + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        // Calibrate one raw count pair
        function htl_out_t linearize(htl_in_t s, bit low_res);
            longint tc;
            longint h;
            longint c1, c2, c3, t1, t2;
            longint acc;
            longint rounded;
            longint rh;
            htl_out_t o;
            h = longint'(s.humid_count);
            if (low_res)
            begin
                tc = -4010 + 4 * longint'(s.temp_count);
                if (tc > 12373)
                    tc = 12373;
                c2 = fixed_coef(5872, 64'd10000);
                c3 = fixed_coef(-40845, 64'd100000000);
                t2 = fixed_coef(128, 64'd100000);
            end
            else
            begin
                tc = -4010 + longint'(s.temp_count);
                c2 = fixed_coef(367, 64'd10000);
                c3 = fixed_coef(-15955, 64'd10000000000);
                t2 = fixed_coef(8, 64'd100000);
            end
            c1 = fixed_coef(-20468, 64'd10000);
            t1 = fixed_coef(1, 64'd100);
            acc = 100 * (c1 + c2 * h + c3 * h * h) + (t1 + t2 * h) * (tc - 2500);
            rounded = acc + (longint'(1) << (FRAC_BITS - 1));
            // Clamp below 0.1 %RH and above 100 %RH
            if (rounded < 10 * (longint'(1) << FRAC_BITS))
                rh = 10;
            else
            begin
                rh = rounded >>> FRAC_BITS;
                if (rh > 10000)
                    rh = 10000;
            end
            o.temp_centi  = tc[14:0];
            o.humid_centi = rh[13:0];
            return o;
        endfunction

        task note_sample(htl_in_t s, bit low_res);
            pending.push_back(linearize(s, low_res));
        endtask

        task check_result(htl_out_t got);
            htl_out_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result beat %h with no sample pending", got));
                return;
            end
            want = pending.pop_front();
            if (got.temp_centi !== want.temp_centi)
                report($sformatf("temp_centi got %0d want %0d",
                                 got.temp_centi, want.temp_centi));
            if (got.humid_centi !== want.humid_centi)
                report($sformatf("humid_centi got %0d want %0d",
                                 got.humid_centi, want.humid_centi));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     sample_valid = 1'b0;
    logic     sample_ready;
    htl_in_t  sample = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    htl_out_t result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data = 1'b0;

    linearizer_scoreboard sb = new();
    bit low_res_setting = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    humidity_temperature_linearizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Record accepted samples, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                sb.note_sample(sample, low_res_setting);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // End the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one sample beat, idling first at random, and hold until taken
    task send_sample(htl_in_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            sample = htl_in_t'(26'($urandom));
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample = s;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    task send_pair(int t, int h);
        htl_in_t s;
        s.temp_count  = t[13:0];
        s.humid_count = h[11:0];
        send_sample(s);
    endtask

    // Drop valid, drain the pipeline, then write the resolution bit
    task set_resolution(bit low_res);
        @(negedge clk);
        sample_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = low_res;
        do
            @(posedge clk);
        while (!cfg_ready);
        low_res_setting = low_res;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = 1'($urandom_range(1));
    endtask

    // Random count pair, biased toward extremes and the used bit range
    function htl_in_t make_reading(bit low_res);
        htl_in_t s;
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: s.temp_count = '0;
            1: s.temp_count = '1;
            default: s.temp_count = (low_res && pick < 6) ? 14'($urandom_range(4095))
                                                          : 14'($urandom_range(16383));
        endcase
        pick = $urandom_range(7);
        case (pick)
            0: s.humid_count = '0;
            1: s.humid_count = '1;
            default: s.humid_count = (low_res && pick < 5) ? 12'($urandom_range(255))
                                                           : 12'($urandom_range(4095));
        endcase
        return s;
    endfunction

    task run_random(bit low_res, int send_pct, int recv_pct);
        set_resolution(low_res);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < RANDOM_PHASE; i++)
            send_sample(make_reading(low_res));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 34;
        recv_stall_pct = 68;

        // High resolution: extremes, 25 C reference point, clamp edges
        set_resolution(1'b0);
        send_pair(0, 0);
        send_pair(16383, 4095);
        send_pair(0, 4095);
        send_pair(16383, 0);
        send_pair(6510, 0);
        send_pair(6510, 2048);
        send_pair(6510, 4095);
        send_pair(6510, 100);
        send_pair(6510, 3500);
        send_pair(6510, 56);
        send_pair(6510, 60);
        send_pair(10000, 3000);

        // Low resolution: saturating temperature and the 8-bit humidity span
        set_resolution(1'b1);
        send_pair(0, 0);
        send_pair(4095, 255);
        send_pair(4096, 100);
        send_pair(16383, 4095);
        send_pair(16383, 0);
        send_pair(1630, 128);
        send_pair(1628, 255);
        send_pair(1628, 4);
        send_pair(1628, 3);
        send_pair(0, 255);
        send_pair(3000, 200);

        // Random phases across both settings and all pressure modes
        run_random(1'b0, 34, 68);
        run_random(1'b1, 34, 68);
        run_random(1'b1, 68, 34);
        run_random(1'b0, 68, 34);
        run_random(1'b0, 0, 0);
        run_random(1'b1, 0, 0);

        @(negedge clk);
        sample_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
